// File: sv/fbma_pkg.sv
package fbma_pkg;

  // Block numbers inside the engine carry one bit more than the ports,
  // since a found block may reach the configured block count minus one.
  localparam int unsigned BLK_W = 11;
  typedef logic [BLK_W-1:0] blk_t;

  // Free map words.
  localparam int unsigned FWORD = 32;
  localparam int unsigned FBIT_W = 5;

  // Request opcodes.
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LOCATE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FREE  = 3'd1;
  localparam logic [2:0] ST_IND_FULL = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_UNMAPPED = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic       direct_valid;
    logic [9:0] direct_block;
    logic       indirect_valid;
    logic [9:0] indirect_block;
    logic [6:0] file_block_index;
    logic [7:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        new_direct_valid;
    logic [9:0]  new_direct_block;
    logic        new_indirect_valid;
    logic [9:0]  new_indirect_block;
    logic [9:0]  physical_block;
    logic [17:0] byte_address;
  } rsp_t;

  // Command classes decided by the front end.
  typedef enum logic [3:0] {
    K_APP_DIR,
    K_APP_NEW,
    K_APP_IND,
    K_REL_IND,
    K_REL_DIR,
    K_REL_NONE,
    K_LOC_DIR,
    K_LOC_IND,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e kind;
    req_t  req;
  } cmd_t;

endpackage

// File: sv/fbma_fifo.sv
module fbma_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage holds no control state.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

// File: sv/fbma_front.sv
module fbma_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fbma_pkg::req_t  req_i,
  input  logic            busy_clear_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output logic            cmd_empty_o,
  output fbma_pkg::cmd_t  cmd_o
);

  import fbma_pkg::*;

  cmd_t                cmd_in;
  logic                q_full;
  logic [$bits(cmd_t)-1:0] q_out;

  // Classify the request by opcode and by the pointers it carries.
  always_comb begin
    cmd_in.req  = req_i;
    cmd_in.kind = K_NOP;
    unique case (req_i.opcode)
      OP_APPEND: begin
        if (!req_i.direct_valid) cmd_in.kind = K_APP_DIR;
        else if (!req_i.indirect_valid) cmd_in.kind = K_APP_NEW;
        else cmd_in.kind = K_APP_IND;
      end
      OP_RELEASE: begin
        if (req_i.indirect_valid) cmd_in.kind = K_REL_IND;
        else if (req_i.direct_valid) cmd_in.kind = K_REL_DIR;
        else cmd_in.kind = K_REL_NONE;
      end
      OP_LOCATE: begin
        if (req_i.file_block_index == '0) cmd_in.kind = K_LOC_DIR;
        else cmd_in.kind = K_LOC_IND;
      end
      default: cmd_in.kind = K_NOP;
    endcase
  end

  // No beat is taken while the stores are being cleared.
  assign full_o = q_full || busy_clear_i;

  fbma_fifo #(
    .Width($bits(cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !full_o),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .empty_o(cmd_empty_o),
    .data_o (q_out)
  );

  assign cmd_o = cmd_t'(q_out);

endmodule

// File: sv/fbma_back.sv
module fbma_back #(
  parameter int unsigned NUM_BLOCKS         = 1024,
  parameter int unsigned MAX_PTRS_PER_BLOCK = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_empty_i,
  input  fbma_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output fbma_pkg::rsp_t  res_o,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [10:0]     cfg_data_i,
  output logic            busy_clear_o
);

  import fbma_pkg::*;

  localparam int unsigned FDepth = (NUM_BLOCKS + FWORD - 1) / FWORD;
  localparam int unsigned FAW    = (FDepth > 1) ? $clog2(FDepth) : 1;
  localparam int unsigned PDepth = NUM_BLOCKS * MAX_PTRS_PER_BLOCK;
  localparam int unsigned PAW    = $clog2(PDepth);
  localparam int unsigned CW     = $clog2(PDepth + 1);
  localparam int unsigned EW     = $clog2(MAX_PTRS_PER_BLOCK + 1);
  localparam logic [16:0]   NB      = 17'(NUM_BLOCKS);
  localparam logic [8:0]    MX      = 9'(MAX_PTRS_PER_BLOCK);
  localparam logic [CW-1:0] ClrLast = CW'(PDepth - 1);
  localparam logic [CW-1:0] FDepthC = CW'(FDepth);
  localparam logic [EW-1:0] ZeroLast = EW'(MAX_PTRS_PER_BLOCK - 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SEQ      = 4'd2;
  localparam logic [3:0] S_FIND_RD  = 4'd3;
  localparam logic [3:0] S_FIND_CHK = 4'd4;
  localparam logic [3:0] S_MARK_RD  = 4'd5;
  localparam logic [3:0] S_MARK_WR  = 4'd6;
  localparam logic [3:0] S_ENT_RD   = 4'd7;
  localparam logic [3:0] S_ENT_CHK  = 4'd8;
  localparam logic [3:0] S_ZERO     = 4'd9;
  localparam logic [3:0] S_PWR      = 4'd10;
  localparam logic [3:0] S_MUL      = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  function automatic logic ent_valid(input blk_t v, input logic [16:0] n);
    return (v != '0) && (17'(v) < n);
  endfunction

  function automatic logic in_range(input blk_t b);
    return 17'(b) < NB;
  endfunction

  function automatic logic [PAW-1:0] paddr(input blk_t b, input logic [EW-1:0] e);
    return PAW'(32'(b) * MAX_PTRS_PER_BLOCK + 32'(e));
  endfunction

  // Memories.
  logic [FWORD-1:0] fmap [FDepth];
  blk_t             pstore [PDepth];
  logic [FWORD-1:0] fm_rdata_q, fm_wdata;
  logic             fm_re, fm_we;
  logic [FAW-1:0]   fm_raddr, fm_waddr;
  blk_t             ps_rdata_q, ps_wdata;
  logic             ps_re, ps_we;
  logic [PAW-1:0]   ps_raddr, ps_waddr;

  // Control and working registers.
  logic [3:0]    state_q, state_d;
  logic [2:0]    step_q, step_d;
  logic          fin_q, fin_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [10:0]   bc_q;
  logic [8:0]    bsz_q;
  kind_e         kind_q, kind_d;
  logic [2:0]    st_q, st_d;
  logic          dv_q, dv_d, iv_q, iv_d;
  blk_t          db_q, db_d, ib_q, ib_d;
  logic [6:0]    idx_q, idx_d;
  logic [7:0]    off_q, off_d;
  blk_t          phys_q, phys_d, f_q, f_d, fnd_q, fnd_d, val_q, val_d;
  blk_t          mblk_q, mblk_d, pwv_q, pwv_d;
  logic [17:0]   addr_q, addr_d;
  logic          fnd_ok_q, fnd_ok_d, ent_ok_q, ent_ok_d;
  logic          mval_q, mval_d, fwd_q, fwd_d, want_q, want_d;
  logic [FAW-1:0] w_q, w_d;
  logic [EW-1:0] ent_q, ent_d, lim_q, lim_d;

  // Derived configuration values.
  logic [16:0]   eff;
  logic [8:0]    np9;
  logic [EW-1:0] np;
  logic [6:0]    pp;

  assign eff = (17'(bc_q) > NB) ? NB : 17'(bc_q);
  assign pp  = bsz_q[8:2];
  assign np9 = (pp == '0) ? 9'd1 : ((9'(pp) > MX) ? MX : 9'(pp));
  assign np  = EW'(np9);

  // Lowest free block in the word just read.
  logic [31:0]       fbase;
  logic [FWORD-1:0]  cand;
  logic [FBIT_W-1:0] hit;
  logic              any;
  always_comb begin
    fbase = 32'(w_q) << FBIT_W;
    hit   = '0;
    any   = 1'b0;
    for (int i = 0; i < FWORD; i++) begin
      cand[i] = !fm_rdata_q[i] && ((fbase + 32'(i)) != 32'd0) &&
                ((fbase + 32'(i)) < 32'(eff));
    end
    for (int i = FWORD - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit = FBIT_W'(i);
        any = 1'b1;
      end
    end
  end

  // Free map word with one bit changed.
  logic [FWORD-1:0] mword;
  always_comb begin
    mword = fm_rdata_q;
    mword[mblk_q[FBIT_W-1:0]] = mval_q;
  end

  // Entry just read from the pointer store.
  blk_t ent_v;
  assign ent_v = in_range(ib_q) ? ps_rdata_q : '0;

  // Sequencer.
  always_comb begin
    state_d  = state_q;  step_d = step_q;   fin_d = fin_q;   clr_d = clr_q;
    kind_d   = kind_q;   st_d   = st_q;     dv_d  = dv_q;    iv_d  = iv_q;
    db_d     = db_q;     ib_d   = ib_q;     idx_d = idx_q;   off_d = off_q;
    phys_d   = phys_q;   f_d    = f_q;      fnd_d = fnd_q;   val_d = val_q;
    mblk_d   = mblk_q;   pwv_d  = pwv_q;    addr_d = addr_q;
    fnd_ok_d = fnd_ok_q; ent_ok_d = ent_ok_q;
    mval_d   = mval_q;   fwd_d  = fwd_q;    want_d = want_q;
    w_d      = w_q;      ent_d  = ent_q;    lim_d  = lim_q;
    fm_re = 1'b0; fm_raddr = w_q; fm_we = 1'b0; fm_waddr = '0; fm_wdata = '0;
    ps_re = 1'b0; ps_raddr = paddr(ib_q, ent_q);
    ps_we = 1'b0; ps_waddr = '0; ps_wdata = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_q[PAW-1:0];
        if (clr_q < FDepthC) begin
          fm_we    = 1'b1;
          fm_waddr = FAW'(clr_q);
          fm_wdata = (clr_q == '0) ? FWORD'(1) : '0;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == ClrLast) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          kind_d = cmd_i.kind;
          dv_d   = cmd_i.req.direct_valid;
          db_d   = BLK_W'(cmd_i.req.direct_block);
          iv_d   = cmd_i.req.indirect_valid;
          ib_d   = BLK_W'(cmd_i.req.indirect_block);
          idx_d  = cmd_i.req.file_block_index;
          off_d  = cmd_i.req.byte_offset;
          st_d   = ST_OK;
          phys_d = '0;
          addr_d = '0;
          fin_d  = 1'b0;
          step_d = '0;
          state_d = S_SEQ;
        end
      end

      S_SEQ: begin
        step_d = step_q + 1'b1;
        if (fin_q) begin
          state_d = S_DONE;
        end else begin
          case (kind_q)
            K_APP_DIR: begin
              if (step_q == 3'd0) begin
                w_d = '0; state_d = S_FIND_RD;
              end else if (!fnd_ok_q) begin
                st_d = ST_NO_FREE; fin_d = 1'b1;
              end else begin
                dv_d = 1'b1; db_d = fnd_q; phys_d = fnd_q;
                mblk_d = fnd_q; mval_d = 1'b1; state_d = S_MARK_RD; fin_d = 1'b1;
              end
            end
            K_APP_NEW: begin
              case (step_q)
                3'd0, 3'd2: begin
                  w_d = '0; state_d = S_FIND_RD;
                end
                3'd1: begin
                  if (!fnd_ok_q) begin
                    st_d = ST_NO_FREE; fin_d = 1'b1;
                  end else begin
                    f_d = fnd_q; mblk_d = fnd_q; mval_d = 1'b1; state_d = S_MARK_RD;
                  end
                end
                3'd3: begin
                  if (!fnd_ok_q) begin
                    // Only one block was free: give the first one back. It is
                    // still cleared below.
                    st_d = ST_NO_FREE;
                    mblk_d = f_q; mval_d = 1'b0; state_d = S_MARK_RD;
                  end else begin
                    phys_d = fnd_q; mblk_d = fnd_q; mval_d = 1'b1; state_d = S_MARK_RD;
                  end
                end
                3'd4: begin
                  ent_d = '0; state_d = S_ZERO;
                end
                default: begin
                  if (st_q == ST_OK) begin
                    iv_d = 1'b1; ib_d = f_q;
                  end
                  fin_d = 1'b1;
                end
              endcase
            end
            K_APP_IND: begin
              case (step_q)
                3'd0: begin
                  ent_d = '0; lim_d = np; fwd_d = 1'b1; want_d = 1'b0;
                  state_d = S_ENT_RD;
                end
                3'd1: begin
                  if (!ent_ok_q) begin
                    st_d = ST_IND_FULL; fin_d = 1'b1;
                  end else begin
                    w_d = '0; state_d = S_FIND_RD;
                  end
                end
                3'd2: begin
                  if (!fnd_ok_q) begin
                    st_d = ST_NO_FREE; fin_d = 1'b1;
                  end else begin
                    phys_d = fnd_q; mblk_d = fnd_q; mval_d = 1'b1; state_d = S_MARK_RD;
                  end
                end
                default: begin
                  pwv_d = phys_q; state_d = S_PWR; fin_d = 1'b1;
                end
              endcase
            end
            K_REL_IND: begin
              case (step_q)
                3'd0: begin
                  ent_d = np - 1'b1; lim_d = np; fwd_d = 1'b0; want_d = 1'b1;
                  state_d = S_ENT_RD;
                end
                3'd1: begin
                  if (ent_ok_q) begin
                    phys_d = val_q; mblk_d = val_q; mval_d = 1'b0;
                  end else begin
                    // No valid entry left: the indirect block itself goes.
                    phys_d = ib_q; iv_d = 1'b0; fin_d = 1'b1;
                    mblk_d = ib_q; mval_d = 1'b0;
                  end
                  state_d = S_MARK_RD;
                end
                3'd2: begin
                  pwv_d = '0; state_d = S_PWR;
                end
                default: begin
                  if (ent_q == '0) begin
                    iv_d = 1'b0; mblk_d = ib_q; mval_d = 1'b0; state_d = S_MARK_RD;
                  end
                  fin_d = 1'b1;
                end
              endcase
            end
            K_REL_DIR: begin
              dv_d = 1'b0; phys_d = db_q; fin_d = 1'b1;
              mblk_d = db_q; mval_d = 1'b0; state_d = S_MARK_RD;
            end
            K_REL_NONE: begin
              st_d = ST_NOTHING; fin_d = 1'b1;
            end
            K_LOC_DIR: begin
              fin_d = 1'b1;
              if (dv_q) begin
                phys_d = db_q; state_d = S_MUL;
              end else begin
                st_d = ST_UNMAPPED;
              end
            end
            K_LOC_IND: begin
              if (step_q == 3'd0) begin
                if (iv_q && (9'(idx_q - 7'd1) < np9)) begin
                  ent_d = '0; lim_d = EW'(idx_q); fwd_d = 1'b1; want_d = 1'b0;
                  state_d = S_ENT_RD;
                end else begin
                  st_d = ST_UNMAPPED; fin_d = 1'b1;
                end
              end else if (ent_ok_q) begin
                st_d = ST_UNMAPPED; fin_d = 1'b1;
              end else begin
                phys_d = val_q; state_d = S_MUL; fin_d = 1'b1;
              end
            end
            default: fin_d = 1'b1;
          endcase
        end
      end

      S_FIND_RD: begin
        fm_re = 1'b1; fm_raddr = w_q; state_d = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        if (any) begin
          fnd_ok_d = 1'b1;
          fnd_d    = BLK_W'(fbase + 32'(hit));
          state_d  = S_SEQ;
        end else if ((fbase + 32'(FWORD)) < 32'(eff)) begin
          w_d = w_q + 1'b1; state_d = S_FIND_RD;
        end else begin
          fnd_ok_d = 1'b0; state_d = S_SEQ;
        end
      end

      S_MARK_RD: begin
        if (mblk_q != '0 && in_range(mblk_q)) begin
          fm_re = 1'b1; fm_raddr = FAW'(mblk_q >> FBIT_W); state_d = S_MARK_WR;
        end else begin
          state_d = S_SEQ;
        end
      end

      S_MARK_WR: begin
        fm_we = 1'b1; fm_waddr = FAW'(mblk_q >> FBIT_W); fm_wdata = mword;
        state_d = S_SEQ;
      end

      S_ENT_RD: begin
        ps_re = 1'b1; ps_raddr = paddr(ib_q, ent_q); state_d = S_ENT_CHK;
      end

      S_ENT_CHK: begin
        val_d = ent_v;
        if (ent_valid(ent_v, eff) == want_q) begin
          ent_ok_d = 1'b1; state_d = S_SEQ;
        end else if (fwd_q) begin
          if ((9'(ent_q) + 9'd1) >= 9'(lim_q)) begin
            ent_ok_d = 1'b0; state_d = S_SEQ;
          end else begin
            ent_d = ent_q + 1'b1; state_d = S_ENT_RD;
          end
        end else if (ent_q == '0) begin
          ent_ok_d = 1'b0; state_d = S_SEQ;
        end else begin
          ent_d = ent_q - 1'b1; state_d = S_ENT_RD;
        end
      end

      S_ZERO: begin
        // Clear the new indirect block; entry 0 gets the new data block, or
        // zero when no second block was free.
        ps_we    = in_range(f_q);
        ps_waddr = paddr(f_q, ent_q);
        ps_wdata = (ent_q == '0) ? phys_q : '0;
        ent_d    = ent_q + 1'b1;
        if (ent_q == ZeroLast) state_d = S_SEQ;
      end

      S_PWR: begin
        ps_we = in_range(ib_q); ps_waddr = paddr(ib_q, ent_q); ps_wdata = pwv_q;
        state_d = S_SEQ;
      end

      S_MUL: begin
        addr_d  = 18'(20'(phys_q) * 20'(bsz_q) + 20'(off_q));
        state_d = S_SEQ;
      end

      S_DONE: begin
        res_push_o = 1'b1; state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_clear_o = (state_q == S_CLEAR);

  // Result beat.
  always_comb begin
    res_o.status             = st_q;
    res_o.new_direct_valid   = dv_q;
    res_o.new_direct_block   = dv_q ? db_q[9:0] : '0;
    res_o.new_indirect_valid = iv_q;
    res_o.new_indirect_block = iv_q ? ib_q[9:0] : '0;
    res_o.physical_block     = phys_q[9:0];
    res_o.byte_address       = addr_q;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= '0;
      fin_q   <= 1'b0;
      clr_q   <= '0;
      bc_q    <= 11'd1024;
      bsz_q   <= 9'd64;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      fin_q   <= fin_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_index_i == CFG_BLOCK_COUNT) bc_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_BLOCK_SIZE) bsz_q <= cfg_data_i[8:0];
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;  st_q <= st_d;    dv_q <= dv_d;    iv_q <= iv_d;
    db_q   <= db_d;    ib_q <= ib_d;    idx_q <= idx_d;  off_q <= off_d;
    phys_q <= phys_d;  f_q <= f_d;      fnd_q <= fnd_d;  val_q <= val_d;
    mblk_q <= mblk_d;  pwv_q <= pwv_d;  addr_q <= addr_d;
    fnd_ok_q <= fnd_ok_d; ent_ok_q <= ent_ok_d;
    mval_q <= mval_d;  fwd_q <= fwd_d;  want_q <= want_d;
    w_q    <= w_d;     ent_q <= ent_d;  lim_q <= lim_d;
  end

  // Free map memory.
  always_ff @(posedge clk_i) begin
    if (fm_we) fmap[fm_waddr] <= fm_wdata;
    if (fm_re) fm_rdata_q <= fmap[fm_raddr];
  end

  // Pointer store memory.
  always_ff @(posedge clk_i) begin
    if (ps_we) pstore[ps_waddr] <= ps_wdata;
    if (ps_re) ps_rdata_q <= pstore[ps_raddr];
  end

endmodule

// File: sv/file_block_map_allocator_unit.sv
// Block allocator with a free-block bitmap and a store of indirect entries.
// Requests enter as a queue: a beat is taken when push is high and full is
// low. Results leave as a queue: the oldest result sits on rsp_o while
// empty is low and is taken when pop is high. Configuration beats use
// cfg_valid_i/cfg_ready_o; ready is always high, index 0 is the block count,
// index 1 is the block size in bytes.
// A front end classifies requests into a two-entry command queue; a back end
// executes one command at a time and pushes into a two-entry result queue.
// Work per request: the bitmap is scanned one 32-bit word at a time, indirect
// entries one at a time (up to MAX_PTRS_PER_BLOCK), and taking an indirect
// block clears all MAX_PTRS_PER_BLOCK of its entries.
// After reset the pointer store and bitmap are cleared, one entry a cycle,
// through all NUM_BLOCKS*MAX_PTRS_PER_BLOCK entries; full stays high meanwhile.
// When the receiver stalls, results wait in the queue; the back end stops
// once that queue is full and the front end keeps taking up to two more.
module file_block_map_allocator_unit #(
  parameter int unsigned NUM_BLOCKS         = 1024,
  parameter int unsigned MAX_PTRS_PER_BLOCK = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  fbma_pkg::req_t  req_i,
  output logic            empty,
  input  logic            pop,
  output fbma_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [10:0]     cfg_data_i
);

  import fbma_pkg::*;

  cmd_t cmd;
  logic cmd_empty, cmd_pop, busy_clear;
  rsp_t res;
  logic res_push, res_full;
  logic [$bits(rsp_t)-1:0] res_out;

  assign cfg_ready_o = 1'b1;

  fbma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .busy_clear_i(busy_clear),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  fbma_back #(
    .NUM_BLOCKS        (NUM_BLOCKS),
    .MAX_PTRS_PER_BLOCK(MAX_PTRS_PER_BLOCK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_clear_o(busy_clear)
  );

  fbma_fifo #(
    .Width($bits(rsp_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_out)
  );

  assign rsp_o = rsp_t'(res_out);

endmodule
